/* src/rrst_pkg.sv */
// ----------------------------------------------------------------------------
// rrst_pkg
// Shared widths, codes and search geometry for the round robin request
// slot table and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rrst_pkg;

  // fixed port widths of the request and result fields
  localparam int unsigned DEV_W      = 4;
  localparam int unsigned TAG_PORT_W = 32;
  localparam int unsigned IDX_PORT_W = 7;
  localparam int unsigned CNT_PORT_W = 8;

  // slot search is split into groups of this many slots
  localparam int unsigned GRP_W     = 16;
  localparam int unsigned GRP_OFF_W = $clog2(GRP_W);

  // request operation codes
  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVICE = 1'b1
  } op_e;

endpackage

`default_nettype wire

/* src/round_robin_request_slot_table.sv */
// ----------------------------------------------------------------------------
// round_robin_request_slot_table
// Slot table with rotating first-free allocation and rotating first-active
// service; per-slot device, handler flag and tag live in one sync memory.
// ----------------------------------------------------------------------------
// Results: enqueue and empty-service results load from the select state;
//   a found service reads the slot memory there and loads from the read state.
// A new request stalls until the last result is registered; the pace is
//   set by the two-level registered slot search and the memory read port.
// Reset: active bitmap, cursors and busy count clear at once; slot memory
//   is not cleared, only active slots (always written first) are read.
`default_nettype none

module round_robin_request_slot_table #(
  parameter int unsigned SLOT_COUNT = 128,
  parameter int unsigned TAG_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  rrst_pkg::op_e                       op_i,
  input  logic [rrst_pkg::DEV_W-1:0]          device_code_i,
  input  logic                                has_handler_i,
  input  logic [rrst_pkg::TAG_PORT_W-1:0]     handler_tag_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                enqueue_ok_o,
  output logic                                table_full_o,
  output logic                                serviced_o,
  output logic [rrst_pkg::IDX_PORT_W-1:0]     slot_index_o,
  output logic                                call_handler_o,
  output logic [rrst_pkg::TAG_PORT_W-1:0]     tag_out_o,
  output logic [rrst_pkg::DEV_W-1:0]          device_out_o,
  output logic [rrst_pkg::CNT_PORT_W-1:0]     pending_count_o
);
  import rrst_pkg::*;

  localparam int unsigned IW         = $clog2(SLOT_COUNT);
  localparam int unsigned CW         = $clog2(SLOT_COUNT + 1);
  localparam int unsigned NG         = (SLOT_COUNT + GRP_W - 1) / GRP_W;
  localparam int unsigned GIW        = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned PAD        = NG * GRP_W;
  localparam int unsigned MW         = 1 + DEV_W + TAG_BITS;
  localparam int unsigned TAG_WIDE_W = (TAG_BITS > TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_READ
  } state_e;

  state_e                state_q;
  logic [SLOT_COUNT-1:0] active_q;
  logic [IW-1:0]         alloc_q;
  logic [IW-1:0]         serv_q;
  logic [CW-1:0]         count_q;

  // captured request
  op_e                   req_op_q;
  logic [DEV_W-1:0]      req_dev_q;
  logic                  req_hh_q;
  logic [TAG_BITS-1:0]   req_tag_q;

  // first search level, one entry per group
  logic [NG-1:0]         grp_hi_d, grp_hi_q;
  logic [NG-1:0]         grp_any_d, grp_any_q;
  logic [GRP_OFF_W-1:0]  off_hi_d [NG];
  logic [GRP_OFF_W-1:0]  off_hi_q [NG];
  logic [GRP_OFF_W-1:0]  off_any_d [NG];
  logic [GRP_OFF_W-1:0]  off_any_q [NG];

  // slot data memory: {has_handler, device, tag}
  logic [MW-1:0]         slot_mem [SLOT_COUNT];
  logic [MW-1:0]         rd_q;

  // result register
  logic                  out_valid_q;
  logic                  ok_q, full_q, serv_flag_q, call_q;
  logic [IDX_PORT_W-1:0] idx_out_q;
  logic [TAG_PORT_W-1:0] tag_out_q;
  logic [DEV_W-1:0]      dev_out_q;
  logic [CNT_PORT_W-1:0] cnt_out_q;

  logic                  in_accept;
  logic [IW-1:0]         cursor;
  logic [PAD-1:0]        cand, cand_hi;
  logic                  use_hi, found;
  logic [GIW-1:0]        sel_grp;
  logic [GRP_OFF_W-1:0]  sel_off;
  logic [IW-1:0]         hit_idx, next_cur;
  logic                  out_free, sel_fire, is_service, out_load;
  logic                  mem_we, mem_re;
  logic [CW-1:0]         count_d;
  logic [TAG_WIDE_W-1:0] tag_in_wide, tag_rd_wide;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cursor     = (op_i == OP_SERVICE) ? serv_q : alloc_q;

  // candidate slots, and those at or after the cursor
  always_comb begin
    cand    = '0;
    cand_hi = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      cand[i]    = (op_i == OP_SERVICE) ? active_q[i] : !active_q[i];
      cand_hi[i] = cand[i] && (32'(i) >= 32'(cursor));
    end
  end

  // per-group first candidate
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hi_d[g]  = |cand_hi[g*GRP_W +: GRP_W];
      grp_any_d[g] = |cand[g*GRP_W +: GRP_W];
      off_hi_d[g]  = '0;
      off_any_d[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (cand_hi[g*GRP_W + b]) off_hi_d[g] = GRP_OFF_W'(b);
        if (cand[g*GRP_W + b])    off_any_d[g] = GRP_OFF_W'(b);
      end
    end
  end

  // second level: first group at or after cursor, else wrap to first group
  always_comb begin
    use_hi  = |grp_hi_q;
    found   = |grp_any_q;
    sel_grp = '0;
    sel_off = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (use_hi ? grp_hi_q[g] : grp_any_q[g]) begin
        sel_grp = GIW'(g);
        sel_off = use_hi ? off_hi_q[g] : off_any_q[g];
      end
    end
  end

  assign hit_idx  = IW'({sel_grp, sel_off});
  assign next_cur = (hit_idx == LAST_SLOT) ? '0 : hit_idx + 1'b1;

  // select step fires when its result can land, or when it only reads memory
  assign is_service = (req_op_q == OP_SERVICE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sel_fire   = (state_q == ST_SELECT) && (out_free || (is_service && found));
  assign mem_we     = sel_fire && found && !is_service;
  assign mem_re     = sel_fire && found && is_service;
  assign count_d    = !found ? count_q :
                      (is_service ? count_q - 1'b1 : count_q + 1'b1);

  // a new result lands in the result register this cycle
  assign out_load   = (sel_fire && !(is_service && found)) ||
                      ((state_q == ST_READ) && out_free);

  assign tag_in_wide = TAG_WIDE_W'(handler_tag_i);
  assign tag_rd_wide = TAG_WIDE_W'(rd_q[TAG_BITS-1:0]);

  // request capture and first search level
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_op_q  <= op_i;
      req_dev_q <= device_code_i;
      req_hh_q  <= has_handler_i;
      req_tag_q <= tag_in_wide[TAG_BITS-1:0];
      grp_hi_q  <= grp_hi_d;
      grp_any_q <= grp_any_d;
      off_hi_q  <= off_hi_d;
      off_any_q <= off_any_d;
    end
  end

  // slot data memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem[hit_idx] <= {req_hh_q, req_dev_q, req_tag_q};
    if (mem_re) rd_q <= slot_mem[hit_idx];
  end

  // sequencer, table state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      alloc_q     <= '0;
      serv_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      full_q      <= 1'b0;
      serv_flag_q <= 1'b0;
      call_q      <= 1'b0;
      idx_out_q   <= '0;
      tag_out_q   <= '0;
      dev_out_q   <= '0;
      cnt_out_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_load) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) state_q <= ST_SELECT;
        end
        ST_SELECT: begin
          if (sel_fire) begin
            count_q <= count_d;
            if (found) begin
              active_q[hit_idx] <= !is_service;
              if (is_service) serv_q <= next_cur;
              else            alloc_q <= next_cur;
            end
            if (is_service && found) begin
              state_q <= ST_READ;
            end else begin
              // enqueue outcome or empty service
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
              ok_q        <= !is_service && found;
              full_q      <= !is_service && !found;
              serv_flag_q <= 1'b0;
              call_q      <= 1'b0;
              idx_out_q   <= found ? IDX_PORT_W'(hit_idx) : '0;
              tag_out_q   <= '0;
              dev_out_q   <= '0;
              cnt_out_q   <= CNT_PORT_W'(count_d);
            end
          end
        end
        ST_READ: begin
          if (out_free) begin
            // retired slot with its stored data
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
            ok_q        <= 1'b0;
            full_q      <= 1'b0;
            serv_flag_q <= 1'b1;
            call_q      <= rd_q[MW-1];
            idx_out_q   <= IDX_PORT_W'(hit_idx);
            tag_out_q   <= rd_q[MW-1] ? tag_rd_wide[TAG_PORT_W-1:0] : '0;
            dev_out_q   <= rd_q[TAG_BITS +: DEV_W];
            cnt_out_q   <= CNT_PORT_W'(count_q);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign enqueue_ok_o    = ok_q;
  assign table_full_o    = full_q;
  assign serviced_o      = serv_flag_q;
  assign slot_index_o    = idx_out_q;
  assign call_handler_o  = call_q;
  assign tag_out_o       = tag_out_q;
  assign device_out_o    = dev_out_q;
  assign pending_count_o = cnt_out_q;

endmodule

`default_nettype wire

/* src/rrst_checker.sv */
// ----------------------------------------------------------------------------
// rrst_checker
// Port-level checks for the round robin request slot table, bound to every
// instance of that module.
// ----------------------------------------------------------------------------
`default_nettype none

module rrst_checker #(
  parameter int unsigned SLOT_COUNT = 128
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input rrst_pkg::op_e                       op_i,
  input logic [rrst_pkg::DEV_W-1:0]          device_code_i,
  input logic                                has_handler_i,
  input logic [rrst_pkg::TAG_PORT_W-1:0]     handler_tag_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic                                enqueue_ok_o,
  input logic                                table_full_o,
  input logic                                serviced_o,
  input logic [rrst_pkg::IDX_PORT_W-1:0]     slot_index_o,
  input logic                                call_handler_o,
  input logic [rrst_pkg::TAG_PORT_W-1:0]     tag_out_o,
  input logic [rrst_pkg::DEV_W-1:0]          device_out_o,
  input logic [rrst_pkg::CNT_PORT_W-1:0]     pending_count_o
);
  import rrst_pkg::*;

  // a stalled request stays offered with its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({op_i, device_code_i, has_handler_i, handler_tag_i}))
    else $error("request changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // at most one outcome flag per result
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({enqueue_ok_o, table_full_o, serviced_o}) <= 1)
    else $error("conflicting outcome flags");

  // handler call only on a retired slot; tag zero without a call, device zero unless serviced
  a_handler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!call_handler_o || serviced_o) &&
                    (call_handler_o || tag_out_o == '0) &&
                    (serviced_o || device_out_o == '0))
    else $error("handler fields inconsistent");

  // a full table reports every slot busy and no slot
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> pending_count_o == CNT_PORT_W'(SLOT_COUNT) &&
                                    slot_index_o == '0)
    else $error("full reported with free slots");

endmodule

bind round_robin_request_slot_table rrst_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_rrst_checker (.*);

`default_nettype wire

/* tb/round_robin_request_slot_table_checker.sv */
// ----------------------------------------------------------------------------
// round_robin_request_slot_table_checker
// Watches both channels of the slot table. Each accepted request goes through
// a local slot table model, and the predicted result waits in a queue. Each
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module round_robin_request_slot_table_checker
  import rrst_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  op_e                   op_i,
  input  logic [DEV_W-1:0]      device_code_i,
  input  logic                  has_handler_i,
  input  logic [TAG_PORT_W-1:0] handler_tag_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  enqueue_ok_i,
  input  logic                  table_full_i,
  input  logic                  serviced_i,
  input  logic [IDX_PORT_W-1:0] slot_index_i,
  input  logic                  call_handler_i,
  input  logic [TAG_PORT_W-1:0] tag_out_i,
  input  logic [DEV_W-1:0]      device_out_i,
  input  logic [CNT_PORT_W-1:0] pending_count_i,
  output int unsigned           fail_count_o,
  output int unsigned           awaiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  enqueue_ok;
    logic                  table_full;
    logic                  serviced;
    logic [IDX_PORT_W-1:0] slot_index;
    logic                  call_handler;
    logic [TAG_PORT_W-1:0] tag_out;
    logic [DEV_W-1:0]      device_out;
    logic [CNT_PORT_W-1:0] pending_count;
  } slot_result_t;

  // local copy of the slot table
  bit                  slot_busy [SLOT_COUNT];
  logic [DEV_W-1:0]    slot_dev  [SLOT_COUNT];
  logic                slot_hnd  [SLOT_COUNT];
  logic [TAG_PORT_W-1:0] slot_tag [SLOT_COUNT];
  int unsigned         busy_total;
  int unsigned         alloc_ptr;
  int unsigned         service_ptr;

  slot_result_t        expected_results[$];
  int unsigned         fail_total;

  // rotating search: first free slot on enqueue, first busy slot on service
  function automatic slot_result_t predict_slot_result(op_e op, logic [DEV_W-1:0] dev,
                                                       logic hh, logic [TAG_PORT_W-1:0] tag);
    slot_result_t res;
    int unsigned  idx;
    bit           found;
    res   = '0;
    found = 1'b0;
    if (op == OP_ENQUEUE) begin
      idx = alloc_ptr;
      for (int n = 0; n < SLOT_COUNT; n++) begin
        if (!found && !slot_busy[idx]) begin
          found          = 1'b1;
          slot_busy[idx] = 1'b1;
          slot_dev[idx]  = dev;
          slot_hnd[idx]  = hh;
          slot_tag[idx]  = tag;
          alloc_ptr      = (idx + 1) % SLOT_COUNT;
          busy_total++;
          res.enqueue_ok = 1'b1;
          res.slot_index = IDX_PORT_W'(idx);
        end
        if (!found) idx = (idx + 1) % SLOT_COUNT;
      end
      res.table_full = !found;
    end else if (busy_total != 0) begin
      idx = service_ptr;
      for (int n = 0; n < SLOT_COUNT; n++) begin
        if (!found && slot_busy[idx]) begin
          found          = 1'b1;
          slot_busy[idx] = 1'b0;
          busy_total--;
          service_ptr    = (idx + 1) % SLOT_COUNT;
          res.serviced   = 1'b1;
          res.slot_index = IDX_PORT_W'(idx);
          res.device_out = slot_dev[idx];
          if (slot_hnd[idx]) begin
            res.call_handler = 1'b1;
            res.tag_out      = slot_tag[idx];
          end
        end
        if (!found) idx = (idx + 1) % SLOT_COUNT;
      end
    end
    res.pending_count = CNT_PORT_W'(busy_total);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [TAG_PORT_W-1:0] want,
                             input logic [TAG_PORT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    if (!rst_ni) begin
      for (int n = 0; n < SLOT_COUNT; n++) slot_busy[n] = 1'b0;
      busy_total   = 0;
      alloc_ptr    = 0;
      service_ptr  = 0;
      expected_results.delete();
      fail_total   = 0;
      fail_count_o <= 0;
      awaiting_o   <= 0;
    end else begin
      // results first, so a request taken at this edge cannot be matched
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with no request outstanding, slot_index %0h",
                   $time, slot_index_i);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("enqueue_ok", want.enqueue_ok, enqueue_ok_i);
          check_field("table_full", want.table_full, table_full_i);
          check_field("serviced", want.serviced, serviced_i);
          check_field("slot_index", want.slot_index, slot_index_i);
          check_field("call_handler", want.call_handler, call_handler_i);
          check_field("tag_out", want.tag_out, tag_out_i);
          check_field("device_out", want.device_out, device_out_i);
          check_field("pending_count", want.pending_count, pending_count_i);
        end
      end
      // requests
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(
          predict_slot_result(op_i, device_code_i, has_handler_i, handler_tag_i));
      end
      fail_count_o <= fail_total;
      awaiting_o   <= expected_results.size();
    end
  end

endmodule

/* tb/tb_round_robin_request_slot_table.sv */
// ----------------------------------------------------------------------------
// tb_round_robin_request_slot_table
// Drives enqueue and service requests into the slot table with random gaps
// and random result back-pressure: a directed opening, a balanced mix, phases
// of mostly enqueues and mostly services, and a last mix with neither gaps nor
// back-pressure. The checker does the comparison.
module tb_round_robin_request_slot_table;
  timeunit 1ns;
  timeprecision 1ps;
  import rrst_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  op_e                   op_i          = OP_ENQUEUE;
  logic [DEV_W-1:0]      device_code_i = '0;
  logic                  has_handler_i = 1'b0;
  logic [TAG_PORT_W-1:0] handler_tag_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  enqueue_ok_o;
  logic                  table_full_o;
  logic                  serviced_o;
  logic [IDX_PORT_W-1:0] slot_index_o;
  logic                  call_handler_o;
  logic [TAG_PORT_W-1:0] tag_out_o;
  logic [DEV_W-1:0]      device_out_o;
  logic [CNT_PORT_W-1:0] pending_count_o;

  int unsigned           fail_count;
  int unsigned           awaiting;
  int unsigned           idle_cycles = 0;
  bit                    calm = 1'b0;

  round_robin_request_slot_table u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .device_code_i,
    .has_handler_i, .handler_tag_i, .out_valid_o, .out_stall_i,
    .enqueue_ok_o, .table_full_o, .serviced_o, .slot_index_o,
    .call_handler_o, .tag_out_o, .device_out_o, .pending_count_o
  );

  round_robin_request_slot_table_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i      (in_stall_o),
    .op_i, .device_code_i, .has_handler_i, .handler_tag_i,
    .out_valid_i     (out_valid_o),
    .out_stall_i,
    .enqueue_ok_i    (enqueue_ok_o),
    .table_full_i    (table_full_o),
    .serviced_i      (serviced_o),
    .slot_index_i    (slot_index_o),
    .call_handler_i  (call_handler_o),
    .tag_out_i       (tag_out_o),
    .device_out_i    (device_out_o),
    .pending_count_i (pending_count_o),
    .fail_count_o    (fail_count),
    .awaiting_o      (awaiting)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result back-pressure in bursts, none once the run is calm
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("round_robin_request_slot_table: mismatch");
      $finish;
    end
  end

  // present one request and hold it until taken
  task automatic send_request(input op_e op, input logic [DEV_W-1:0] dev,
                              input logic hh, input logic [TAG_PORT_W-1:0] tag);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    device_code_i <= dev;
    has_handler_i <= hh;
    handler_tag_i <= tag;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // random request, enqueue chosen with the given percentage
  task automatic send_random(input int unsigned enq_pct);
    logic [TAG_PORT_W-1:0] tag;
    tag = $urandom();
    case ($urandom_range(0, 15))
      0:       tag = '0;
      1:       tag = '1;
      default: ;
    endcase
    send_request(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_SERVICE,
                 DEV_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), tag);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty service, field extremes, with and without handler
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_ENQUEUE, 4'h0, 1'b0, 32'h0000_0000);
    send_request(OP_ENQUEUE, 4'hf, 1'b1, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 4'h5, 1'b1, 32'h0000_0000);
    send_request(OP_ENQUEUE, 4'ha, 1'b0, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 4'hf, 1'b1, 32'ha5a5_5a5a);
    send_request(OP_SERVICE, 4'hf, 1'b1, 32'hffff_ffff);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_ENQUEUE, 4'h3, 1'b1, 32'h8000_0001);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);
    send_request(OP_SERVICE, 4'hf, 1'b1, 32'hffff_ffff);
    send_request(OP_ENQUEUE, 4'h9, 1'b1, 32'h1234_5678);
    send_request(OP_SERVICE, 4'h0, 1'b0, '0);

    // balanced mix
    repeat (150) send_random(50);
    // fill the table toward full with mostly enqueues
    repeat (200) send_random(90);
    // hold off until every result is back
    wait_drained();
    // drain the table with mostly services
    repeat (200) send_random(15);
    // last part without any idling
    calm = 1'b1;
    repeat (90) send_random(50);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && awaiting == 0) begin
      $display("round_robin_request_slot_table: match");
    end else begin
      $display("round_robin_request_slot_table: mismatch");
    end
    $finish;
  end

endmodule
